[rtl/htc_pkg.sv]
// ----------------------------------------------------------------------------
// htc_pkg - shared types and constants for the hold-to-confirm timer
// Sequencer states, field widths and the per-mille scale.
// ----------------------------------------------------------------------------
package htc_pkg;

    localparam int TIME_BITS_DEF = 40;
    localparam int REQ_BITS      = 16;
    localparam int PROG_BITS     = 10;
    localparam int PROD_BITS     = REQ_BITS + PROG_BITS;
    localparam int CNT_BITS      = $clog2(PROG_BITS);

    localparam logic [REQ_BITS-1:0]  REQ_RESET     = 16'd1000;
    localparam logic [PROG_BITS-1:0] PERMILLE_FULL = 10'd1000;
    localparam logic [PROG_BITS-1:0] PERMILLE_ZERO = 10'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCALE,
        S_DIVIDE,
        S_EMIT
    } t_state;

endpackage

[rtl/hold_to_confirm_timer_core.sv]
// ----------------------------------------------------------------------------
// hold_to_confirm_timer_core - long-press detector with per-mille progress
// Tracks a button hold against a programmable time and reports a one-shot
// fire pulse plus hold progress for every sample word.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready     | i_button_held, i_time_now_ms
//  out     | output    | o_out_valid / i_out_ready   | o_confirm_fired, o_hold_progress
//  cfg     | input     | i_cfg_wr_en (no wait)       | i_cfg_wr_data (required_hold_ms)
//
//  Steps: a word that needs a progress division goes from accept to result
//  through evaluate, scale, 10 restoring-divide steps and emit; every other
//  word goes through evaluate and emit only. The divide loop runs through the
//  one shared compare/subtract unit at one quotient bit per cycle.
//  Reset: synchronous, active low; clears the hold state, loads the required
//  time with 1000 ms and empties the output register.
//  Stalls: the result sits in the output register; a new word is taken while
//  it waits, and the next result waits in EMIT until the register frees up.
// ----------------------------------------------------------------------------
module hold_to_confirm_timer_core #(
    parameter int TIME_BITS = htc_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [htc_pkg::REQ_BITS-1:0]  i_cfg_wr_data,
    // sample words in
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_button_held,
    input  logic [TIME_BITS-1:0]          i_time_now_ms,
    // result words out
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_confirm_fired,
    output logic [htc_pkg::PROG_BITS-1:0] o_hold_progress
);
    import htc_pkg::*;

    t_state                r_state, n_state;

    // configuration and hold state
    logic [REQ_BITS-1:0]   r_req;
    logic [TIME_BITS-1:0]  r_start, n_start;
    logic                  r_active, n_active;
    logic                  r_done, n_done;

    // captured sample word
    logic                  r_held;
    logic [TIME_BITS-1:0]  r_now;

    // divider datapath: remainder and dividend/quotient shift register
    logic [REQ_BITS-1:0]   r_rem, n_rem;
    logic [PROG_BITS-1:0]  r_quo, n_quo;
    logic [REQ_BITS-1:0]   r_elapsed, n_elapsed;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;

    // pending result
    logic                  r_fired, n_fired;
    logic [PROG_BITS-1:0]  r_prog, n_prog;
    logic                  n_eval_div;

    // output register
    logic                  r_out_valid;
    logic                  r_out_fired;
    logic [PROG_BITS-1:0]  r_out_prog;

    // shared arithmetic
    logic [TIME_BITS:0]    diff;
    logic                  went_back;
    logic                  reached;
    logic [PROD_BITS-1:0]  product;
    logic [REQ_BITS:0]     trial;
    logic                  trial_ge;
    logic                  emit_go;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_confirm_fired = r_out_fired;
    assign o_hold_progress = r_out_prog;

    // Elapsed time with borrow; the borrow flags a timestamp that went backwards.
    assign diff      = {1'b0, r_now} - {1'b0, r_start};
    assign went_back = diff[TIME_BITS];
    assign reached   = (diff[TIME_BITS-1:REQ_BITS] != '0) ||
                       (diff[REQ_BITS-1:0] >= r_req);

    assign product = PROD_BITS'(r_elapsed) * PROD_BITS'(PERMILLE_FULL);

    // Restoring divide step: shift in the next dividend bit, subtract if it fits.
    assign trial    = {r_rem, r_quo[PROG_BITS-1]};
    assign trial_ge = (trial >= {1'b0, r_req});

    // The output register frees up this cycle or is already empty.
    assign emit_go = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = n_eval_div ? S_SCALE : S_EMIT;
            end
            S_SCALE: begin
                n_state = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (r_cnt == CNT_BITS'(PROG_BITS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and hold-state updates per state
    always_comb begin
        n_start    = r_start;
        n_active   = r_active;
        n_done     = r_done;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_elapsed  = r_elapsed;
        n_cnt      = r_cnt;
        n_fired    = r_fired;
        n_prog     = r_prog;
        n_eval_div = 1'b0;
        case (r_state)
            S_EVAL: begin
                n_fired = 1'b0;
                n_prog  = PERMILLE_ZERO;
                if (r_req == '0) begin
                    // disabled: leave the state alone, report zeros
                end else if (!r_held) begin
                    // release: drop the hold
                    n_start  = '0;
                    n_active = 1'b0;
                    n_done   = 1'b0;
                end else if (r_done) begin
                    n_prog = PERMILLE_FULL;
                end else if (!r_active || went_back) begin
                    // first held sample, or time ran backwards: restart here
                    n_start  = r_now;
                    n_active = 1'b1;
                end else if (reached) begin
                    n_done  = 1'b1;
                    n_fired = 1'b1;
                    n_prog  = PERMILLE_FULL;
                end else begin
                    n_elapsed  = diff[REQ_BITS-1:0];
                    n_eval_div = 1'b1;
                end
            end
            S_SCALE: begin
                {n_rem, n_quo} = product;
                n_cnt          = '0;
            end
            S_DIVIDE: begin
                n_rem = trial_ge ? REQ_BITS'(trial - {1'b0, r_req}) : trial[REQ_BITS-1:0];
                n_quo = {r_quo[PROG_BITS-2:0], trial_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(PROG_BITS - 1)) begin
                    n_prog = {r_quo[PROG_BITS-2:0], trial_ge};
                end
            end
            default: begin
            end
        endcase
    end

    // Control and hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req       <= REQ_RESET;
            r_start     <= '0;
            r_active    <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_start  <= n_start;
            r_active <= n_active;
            r_done   <= n_done;
            if (i_cfg_wr_en) begin
                r_req <= i_cfg_wr_data;
            end
            if (r_state == S_EMIT && emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_held <= i_button_held;
            r_now  <= i_time_now_ms;
        end
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_elapsed <= n_elapsed;
        r_cnt     <= n_cnt;
        r_fired   <= n_fired;
        r_prog    <= n_prog;
        if (r_state == S_EMIT && emit_go) begin
            r_out_fired <= r_fired;
            r_out_prog  <= r_prog;
        end
    end

endmodule

[rtl/htc_checker.sv]
// ----------------------------------------------------------------------------
// htc_checker - port-level checks for the hold-to-confirm timer
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module htc_checker #(
    parameter int TIME_BITS = htc_pkg::TIME_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_wr_en,
    input logic [htc_pkg::REQ_BITS-1:0]  i_cfg_wr_data,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_button_held,
    input logic [TIME_BITS-1:0]          i_time_now_ms,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_confirm_fired,
    input logic [htc_pkg::PROG_BITS-1:0] o_hold_progress
);
    import htc_pkg::*;

    // A fire pulse always comes with full progress.
    a_fire_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_confirm_fired) |-> (o_hold_progress == PERMILLE_FULL))
        else $error("fire without full progress");

    // The sequencer is busy the cycle after a word is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accept");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_confirm_fired) && $stable(o_hold_progress)))
        else $error("stalled result changed");

    // A waiting sample word holds until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=>
            (i_in_valid && $stable(i_button_held) && $stable(i_time_now_ms)))
        else $error("waiting sample word changed");

    // Load the required time only while the sequencer is idle.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |-> (o_in_ready && !$isunknown(i_cfg_wr_data)))
        else $error("config write while busy");

endmodule

bind hold_to_confirm_timer_core htc_checker #(.TIME_BITS(TIME_BITS)) u_htc_checker (.*);
